### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the ack reply cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### sv/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Types and constants of the ack reply cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arc_pkg;

  localparam logic       MODE_STORE         = 1'b0;
  localparam logic       MODE_LOOKUP        = 1'b1;
  localparam logic       STATUS_OK          = 1'b0;
  localparam logic       STATUS_BAD_PAYLOAD = 1'b1;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd5000;

  typedef struct packed {
    logic        mode;
    logic [15:0] origin_network;
    logic [15:0] origin_node;
    logic [15:0] sequence_req;
    logic [31:0] now_ms;
    logic [15:0] ack_handle;
    logic        payload_ok;
    logic        ack_required;
  } arc_in_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [15:0] found_handle;
  } arc_out_t;

  typedef struct packed {
    logic [15:0] network;
    logic [15:0] node;
    logic [15:0] sequence_num;
    logic [31:0] stored_time;
    logic [15:0] handle;
  } arc_entry_t;

  // Result of the shared age unit for the entry under inspection.
  typedef struct packed {
    logic [31:0] age;
    logic        expired;
    logic        older;
  } arc_age_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } arc_state_e;

endpackage

### sv/arc_age_unit.sv
// ----------------------------------------------------------------------------
// arc_age_unit
// Shared age unit: wrapped entry age, expiry test and oldest-entry compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_age_unit (
  input  logic [31:0]     now_i,
  input  logic [31:0]     stored_i,
  input  logic [31:0]     timeout_i,
  input  logic [31:0]     best_age_i,
  output arc_pkg::arc_age_t res_o
);

  logic [31:0] age;

  // Modulo 2^32 subtraction gives the wrapped age directly.
  assign age         = now_i - stored_i;
  assign res_o.age     = age;
  assign res_o.expired = (age >= timeout_i);
  assign res_o.older   = (age > best_age_i);

endmodule

### sv/arc_entry_store.sv
// ----------------------------------------------------------------------------
// arc_entry_store
// Entry memory with registered read port, plus per-entry valid flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_entry_store #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IDX_W   = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output arc_pkg::arc_entry_t  rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  arc_pkg::arc_entry_t  wr_data_i,
  input  logic                 clr_en_i,
  input  logic [IDX_W-1:0]     clr_idx_i,
  output logic [ENTRIES-1:0]   valid_o
);

  arc_pkg::arc_entry_t mem [ENTRIES];
  arc_pkg::arc_entry_t rd_data_q;
  logic [ENTRIES-1:0]  valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // Only valid entries are ever looked at, so the memory itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

### sv/ack_reply_cache.sv
// A store with valid payload and a lookup with ack required scan the entries,
// one entry per cycle; a store then writes its entry in ST_WRITE before its
// result is registered. Invalid-payload stores and lookups without ack required
// skip the scan and go straight to ST_RESP.
// One item at a time; a new item is taken once the result sits in the output register.
// Reset clears all valid bits and sets timeout_ms to 5000; no clearing pass.
// ----------------------------------------------------------------------------
// ack_reply_cache
// Timed acknowledgement cache with expiry, lookup and oldest-entry replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ack_reply_cache #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  arc_pkg::arc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output arc_pkg::arc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

  arc_pkg::arc_state_e state_q, state_d;
  arc_pkg::arc_in_t    req_q, req_d;
  arc_pkg::arc_out_t   res_q, res_d;
  arc_pkg::arc_out_t   out_data_q, out_data_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         timeout_q;

  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             proc_vld_q, proc_vld_d;
  logic [IDX_W-1:0] proc_idx_q, proc_idx_d;
  logic             match_found_q, match_found_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic [15:0]      match_handle_q, match_handle_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             old_found_q, old_found_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic [31:0]      best_age_q, best_age_d;

  logic                 rd_en, wr_en, clr_en;
  logic [IDX_W-1:0]     rd_idx, wr_idx;
  arc_pkg::arc_entry_t  rd_data, wr_data;
  logic [CACHE_ENTRIES-1:0] valid;
  arc_pkg::arc_age_t    age_res;
  logic                 cur_valid, cur_live, key_eq;

  arc_entry_store #(
    .ENTRIES (CACHE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .clr_en_i  (clr_en),
    .clr_idx_i (proc_idx_q),
    .valid_o   (valid)
  );

  arc_age_unit u_age (
    .now_i      (req_q.now_ms),
    .stored_i   (rd_data.stored_time),
    .timeout_i  (timeout_q),
    .best_age_i (best_age_q),
    .res_o      (age_res)
  );

  assign cur_valid = valid[proc_idx_q];
  assign cur_live  = cur_valid && !age_res.expired;
  assign key_eq    = (rd_data.network == req_q.origin_network) &&
                     (rd_data.node == req_q.origin_node) &&
                     (rd_data.sequence_num == req_q.sequence_req);
  assign rd_idx    = rd_cnt_q[IDX_W-1:0];

  assign wr_data.network      = req_q.origin_network;
  assign wr_data.node         = req_q.origin_node;
  assign wr_data.sequence_num = req_q.sequence_req;
  assign wr_data.stored_time  = req_q.now_ms;
  assign wr_data.handle       = req_q.ack_handle;

  // Replacement order: matching entry, then first free slot, then oldest entry.
  always_comb begin
    priority if (match_found_q) begin
      wr_idx = match_idx_q;
    end else if (free_found_q) begin
      wr_idx = free_idx_q;
    end else begin
      wr_idx = old_idx_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    res_d          = res_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_data_d     = out_data_q;
    rd_cnt_d       = rd_cnt_q;
    proc_vld_d     = 1'b0;
    proc_idx_d     = proc_idx_q;
    match_found_d  = match_found_q;
    match_idx_d    = match_idx_q;
    match_handle_d = match_handle_q;
    free_found_d   = free_found_q;
    free_idx_d     = free_idx_q;
    old_found_d    = old_found_q;
    old_idx_d      = old_idx_q;
    best_age_d     = best_age_q;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    clr_en         = 1'b0;

    unique case (state_q)
      arc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d              = in_data_i;
          res_d.status       = arc_pkg::STATUS_OK;
          res_d.hit          = 1'b0;
          res_d.found_handle = '0;
          rd_cnt_d           = '0;
          match_found_d      = 1'b0;
          free_found_d       = 1'b0;
          old_found_d        = 1'b0;
          best_age_d         = '0;
          if (in_data_i.mode == arc_pkg::MODE_STORE && !in_data_i.payload_ok) begin
            res_d.status = arc_pkg::STATUS_BAD_PAYLOAD;
            state_d      = arc_pkg::ST_RESP;
          end else if (in_data_i.mode == arc_pkg::MODE_LOOKUP &&
                       !in_data_i.ack_required) begin
            state_d = arc_pkg::ST_RESP;
          end else begin
            state_d = arc_pkg::ST_SCAN;
          end
        end
      end
      arc_pkg::ST_SCAN: begin
        if (rd_cnt_q < CNT_END) begin
          rd_en      = 1'b1;
          rd_cnt_d   = CNT_W'(rd_cnt_q + 1'b1);
          proc_vld_d = 1'b1;
          proc_idx_d = rd_idx;
        end
        // Read data for proc_idx_q arrives in the cycle after its address.
        if (proc_vld_q) begin
          clr_en = cur_valid && age_res.expired;
          if (cur_live && key_eq && !match_found_q) begin
            match_found_d  = 1'b1;
            match_idx_d    = proc_idx_q;
            match_handle_d = rd_data.handle;
          end
          if (!cur_live && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = proc_idx_q;
          end
          // Strict compare keeps the lowest index on equal ages.
          if (cur_live && (!old_found_q || age_res.older)) begin
            old_found_d = 1'b1;
            old_idx_d   = proc_idx_q;
            best_age_d  = age_res.age;
          end
          if (proc_idx_q == LAST_IDX) begin
            if (req_q.mode == arc_pkg::MODE_STORE) begin
              state_d = arc_pkg::ST_WRITE;
            end else begin
              res_d.hit          = match_found_d;
              res_d.found_handle = match_found_d ? match_handle_d : 16'd0;
              state_d            = arc_pkg::ST_RESP;
            end
          end
        end
      end
      arc_pkg::ST_WRITE: begin
        wr_en   = 1'b1;
        state_d = arc_pkg::ST_RESP;
      end
      arc_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = arc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      proc_vld_q  <= 1'b0;
      rd_cnt_q    <= '0;
      timeout_q   <= arc_pkg::TIMEOUT_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      proc_vld_q  <= proc_vld_d;
      rd_cnt_q    <= rd_cnt_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q          <= req_d;
    res_q          <= res_d;
    out_data_q     <= out_data_d;
    proc_idx_q     <= proc_idx_d;
    match_found_q  <= match_found_d;
    match_idx_q    <= match_idx_d;
    match_handle_q <= match_handle_d;
    free_found_q   <= free_found_d;
    free_idx_q     <= free_idx_d;
    old_found_q    <= old_found_d;
    old_idx_q      <= old_idx_d;
    best_age_q     <= best_age_d;
  end

  assign in_stall_o  = (state_q != arc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `ASSERT_PROP(a_proc_in_scan, clk_i, rst_ni, proc_vld_q |-> (state_q == arc_pkg::ST_SCAN))
  `ASSERT_PROP(a_write_then_resp, clk_i, rst_ni, wr_en |=> (state_q == arc_pkg::ST_RESP))
  `ASSERT_NEVER(a_handle_without_hit, clk_i, rst_ni, out_valid_o && !out_data_o.hit && (out_data_o.found_handle != 16'd0))
  `ASSERT_NEVER(a_bad_status_hit, clk_i, rst_ni, out_valid_o && (out_data_o.status == arc_pkg::STATUS_BAD_PAYLOAD) && out_data_o.hit)

endmodule

### test/ack_cache_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_cache_sb_pkg
// Scoreboard for the ack reply cache. It keeps its own copy of the timed
// cache and the timeout register, predicts one result per accepted transfer,
// and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------

package ack_cache_sb_pkg;

  import arc_pkg::*;

  localparam int CACHE_SLOTS  = 8;
  localparam int REPORT_LIMIT = 10;

  class ack_cache_scoreboard;
    logic [31:0] timeout_ms;
    bit          slot_live [CACHE_SLOTS];
    arc_entry_t  slot_entry [CACHE_SLOTS];
    arc_out_t    expected_q [$];
    int          mismatches;

    function new();
      timeout_ms = TIMEOUT_RESET;
      mismatches = 0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_entry[i] = '0;
      end
    endfunction

    function void set_timeout(logic [31:0] value);
      timeout_ms = value;
    endfunction

    // Ages wrap modulo 2^32, so an entry stored "in the future" looks very old.
    function void expire_stale(logic [31:0] now);
      logic [31:0] age;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        age = now - slot_entry[i].stored_time;
        if (slot_live[i] && age >= timeout_ms) slot_live[i] = 1'b0;
      end
    endfunction

    function int find_key(arc_in_t op);
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (slot_live[i] && slot_entry[i].sequence_num == op.sequence_req &&
            slot_entry[i].network == op.origin_network &&
            slot_entry[i].node == op.origin_node) return i;
      end
      return -1;
    endfunction

    // First free slot, else the oldest entry with the lowest index on a tie.
    function int pick_victim(logic [31:0] now);
      int          best;
      logic [31:0] best_age;
      logic [31:0] age;
      best     = 0;
      best_age = '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (!slot_live[i]) return i;
        age = now - slot_entry[i].stored_time;
        if (i == 0 || age > best_age) begin
          best     = i;
          best_age = age;
        end
      end
      return best;
    endfunction

    function void note_input(arc_in_t op);
      arc_out_t res;
      int       slot;
      res = '0;
      if (op.mode == MODE_STORE) begin
        if (!op.payload_ok) begin
          res.status = STATUS_BAD_PAYLOAD;
        end else begin
          expire_stale(op.now_ms);
          slot = find_key(op);
          if (slot < 0) slot = pick_victim(op.now_ms);
          slot_live[slot]               = 1'b1;
          slot_entry[slot].network      = op.origin_network;
          slot_entry[slot].node         = op.origin_node;
          slot_entry[slot].sequence_num = op.sequence_req;
          slot_entry[slot].stored_time  = op.now_ms;
          slot_entry[slot].handle       = op.ack_handle;
        end
      end else if (op.ack_required) begin
        expire_stale(op.now_ms);
        slot = find_key(op);
        if (slot >= 0) begin
          res.hit          = 1'b1;
          res.found_handle = slot_entry[slot].handle;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(arc_out_t got);
      arc_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d hit %0d handle %h",
                   got.status, got.hit, got.found_handle);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.found_handle !== want.found_handle) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected status %0d hit %0d handle %h, got status %0d hit %0d handle %h",
                   want.status, want.hit, want.found_handle,
                   got.status, got.hit, got.found_handle);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### test/tb_ack_reply_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_reply_cache
// Self-checking bench for the ack reply cache: a directed sequence covering
// store, rewrite, replacement, expiry and time wrap, then random traffic over
// a small key pool under several timeout settings and idle patterns.
// ----------------------------------------------------------------------------

module tb_ack_reply_cache;

  import arc_pkg::*;
  import ack_cache_sb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SEGMENTS      = 10;
  localparam int SEGMENT_ITEMS = 100;
  localparam int KEY_POOL      = 12;
  localparam int SETTLE_CYCLES = 20;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  arc_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  arc_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [31:0] cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  ack_cache_scoreboard acks;
  logic [31:0] tmo_now;
  logic [31:0] cur_ms;
  arc_in_t     key_pool [KEY_POOL];

  ack_reply_cache #(
    .CACHE_ENTRIES(CACHE_SLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL ack_reply_cache");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Every transfer on the three channels is seen here, before the edge updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) acks.set_timeout(cfg_data);
      if (in_valid && !in_stall) acks.note_input(in_data);
      if (out_valid && !out_stall) acks.check_result(out_data);
    end
  end

  function automatic arc_in_t pack_op(logic mode, logic [15:0] net, logic [15:0] node,
                                      logic [15:0] seq, logic [31:0] now,
                                      logic [15:0] handle, logic pok, logic areq);
    arc_in_t op;
    op.mode           = mode;
    op.origin_network = net;
    op.origin_node    = node;
    op.sequence_req   = seq;
    op.now_ms         = now;
    op.ack_handle     = handle;
    op.payload_ok     = pok;
    op.ack_required   = areq;
    return op;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input arc_in_t op);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do begin
      @(posedge clk_i);
      taken = !in_stall;
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (acks.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    bit taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk_i);
      taken = cfg_ready;
      @(negedge clk_i);
    end while (!taken);
    cfg_valid <= 1'b0;
    tmo_now = value;
  endtask

  initial begin
    arc_in_t     op;
    logic [31:0] step;
    logic [31:0] span;
    logic [15:0] net;
    logic [15:0] node;
    int          r;
    int          k;

    acks      = new();
    tmo_now   = TIMEOUT_RESET;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, running on the reset value of the timeout.
    send_idle_pct  = 35;
    recv_stall_pct = 47;
    send_item(pack_op(MODE_LOOKUP, 16'h1234, 16'h0001, 16'h0007, 32'd100, 16'h0, 1'b1, 1'b1));
    send_item(pack_op(MODE_STORE, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd100, 16'hFFFF, 1'b1, 1'b0));
    send_item(pack_op(MODE_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd150, 16'h0, 1'b0, 1'b1));
    send_item(pack_op(MODE_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd150, 16'h0, 1'b1, 1'b0));
    // A bad payload must leave the cached entry untouched.
    send_item(pack_op(MODE_STORE, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd160, 16'h5555, 1'b0, 1'b1));
    send_item(pack_op(MODE_STORE, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd200, 16'h0000, 1'b1, 1'b1));
    send_item(pack_op(MODE_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd210, 16'h0, 1'b1, 1'b1));
    send_item(pack_op(MODE_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFE, 32'd210, 16'h0, 1'b1, 1'b1));
    // Fill the remaining slots, with pairs stored at the same time.
    for (int i = 1; i < CACHE_SLOTS; i++)
      send_item(pack_op(MODE_STORE, 16'h0000, 16'hFFFF, 16'(i), 32'(300 + 100 * (i / 2)),
                        16'(16'h0100 + i), 1'b1, 1'b1));
    // Full cache: the oldest entry is replaced.
    send_item(pack_op(MODE_STORE, 16'h8000, 16'h8000, 16'h0000, 32'd700, 16'hA5A5, 1'b1, 1'b0));
    send_item(pack_op(MODE_LOOKUP, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd700, 16'h0, 1'b1, 1'b1));
    // Age exactly equal to the timeout expires the entry.
    send_item(pack_op(MODE_LOOKUP, 16'h0000, 16'hFFFF, 16'h0001, 32'd5300, 16'h0, 1'b1, 1'b1));
    send_item(pack_op(MODE_STORE, 16'h5A5A, 16'hA5A5, 16'h1234, 32'd5300, 16'h7777, 1'b1, 1'b1));
    // Time wraps between store and lookup.
    send_item(pack_op(MODE_STORE, 16'h00FF, 16'hFF00, 16'h8001, 32'hFFFF_FFF0, 16'h8888,
                      1'b1, 1'b0));
    send_item(pack_op(MODE_LOOKUP, 16'h00FF, 16'hFF00, 16'h8001, 32'h0000_0010, 16'hFFFF,
                      1'b0, 1'b1));
    send_item(pack_op(MODE_STORE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0010, 16'h0000,
                      1'b1, 1'b0));
    send_item(pack_op(MODE_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0011, 16'h0000,
                      1'b0, 1'b1));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: write_timeout(32'd1);
        1: write_timeout(32'hFFFF_FFFF);
        2: write_timeout(32'd250);
        3: write_timeout(32'd0);
        4: write_timeout(32'd3000);
        5: write_timeout(32'($urandom_range(2, 100)));
        6: write_timeout($urandom);
        7: write_timeout(32'd60);
        8: write_timeout(32'd1000);
        default: write_timeout(TIMEOUT_RESET);
      endcase
      if (seg < 4) begin
        send_idle_pct  = 35;
        recv_stall_pct = 47;
      end else if (seg < 7) begin
        send_idle_pct  = 47;
        recv_stall_pct = 35;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      // A small pool of keys, some sharing an address, so that hits and
      // replacements are frequent.
      net  = 16'($urandom);
      node = 16'($urandom);
      for (int i = 0; i < KEY_POOL; i++) begin
        if (i % 3 == 0) begin
          net  = 16'($urandom);
          node = 16'($urandom);
        end
        key_pool[i] = pack_op(MODE_STORE, net, node, 16'($urandom), 32'd0, 16'd0, 1'b1, 1'b1);
      end
      cur_ms = (seg == 2) ? 32'hFFFF_F000 : $urandom;
      span   = (tmo_now > 32'd2000) ? 32'd800 : tmo_now / 3 + 32'd1;

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 20) step = 32'd0;
        else if (r < 85) step = $urandom_range(0, span);
        else if (r < 93) step = tmo_now + 32'($urandom_range(0, 2)) - 32'd1;
        else if (r < 97) step = 32'hFFFF_FFFF;
        else step = $urandom;
        cur_ms += step;

        if ($urandom_range(99) < 8) begin
          op = pack_op(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          k  = $urandom_range(0, KEY_POOL - 1);
          op = key_pool[k];
          op.mode         = ($urandom_range(99) < 50) ? MODE_STORE : MODE_LOOKUP;
          op.now_ms       = cur_ms;
          op.ack_handle   = 16'($urandom);
          op.payload_ok   = ($urandom_range(99) < 92);
          op.ack_required = ($urandom_range(99) < 90);
        end
        send_item(op);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (acks.mismatches == 0 && acks.pending() == 0) begin
      $display("PASS ack_reply_cache");
    end else begin
      $display("FAIL ack_reply_cache");
    end
    $finish;
  end

endmodule
